[src/ipv6_text_address_parser_top_defines.svh]
// Assertion macros for the IPv6 text address parser.
// Included by the top level; no other dependencies.
`ifndef IPV6_TEXT_ADDRESS_PARSER_TOP_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IPV6P_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define IPV6P_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IPV6P_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define IPV6P_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/ipv6p_pkg.sv]
// Shared types and constants for the IPv6 text address parser.
// No dependencies.
package ipv6p_pkg;

    localparam int GROUPS  = 8;
    localparam int GROUP_W = 16;
    localparam int HALF_W  = 64;

    typedef logic [GROUP_W-1:0] group_t;

    typedef struct packed {
        logic              ok;
        logic [HALF_W-1:0] addr_high;
        logic [HALF_W-1:0] addr_low;
    } ipv6p_result_t;

endpackage

[src/ipv6p_core.sv]
// Per-character parse state and address slot registers for the IPv6 parser.
// Depends on ipv6p_pkg.
module ipv6p_core
    import ipv6p_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    ch,
    input  logic          end_mark,
    output ipv6p_result_t result
);

    localparam logic [2:0] PH_START       = 3'd0;
    localparam logic [2:0] PH_LEAD_COLON  = 3'd1;
    localparam logic [2:0] PH_IN_GROUP    = 3'd2;
    localparam logic [2:0] PH_AFTER_COLON = 3'd3;
    localparam logic [2:0] PH_AFTER_GAP   = 3'd4;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [3:0] FULL_GROUPS = 4'(GROUPS);
    localparam logic [2:0] MAX_DIGITS = 3'd4;

    // bit 4: is a hex digit, bits 3:0: digit value
    function automatic logic [4:0] hex_class(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    logic [2:0] phase_reg, phase_next;
    logic [3:0] group_count_reg, group_count_next;
    logic [3:0] gap_at_reg, gap_at_next;
    logic       gap_seen_reg, gap_seen_next;
    group_t     group_value_reg, group_value_next;
    logic [2:0] digit_count_reg, digit_count_next;
    logic       failed_reg, failed_next;
    group_t     slot_reg [GROUPS];
    group_t     slot_next [GROUPS];
    group_t     shift_src [GROUPS];

    logic [4:0] hc;
    logic       is_digit, is_colon;
    logic [3:0] digit;
    logic       do_close, close_fail, clear_gap;
    logic [3:0] gap_pos;
    logic [3:0] final_count;
    logic       ok;

    assign hc       = hex_class(ch);
    assign is_digit = hc[4];
    assign digit    = hc[3:0];
    assign is_colon = (ch == CH_COLON);
    assign close_fail = (group_count_reg >= FULL_GROUPS);

    always_comb begin
        phase_next       = phase_reg;
        group_count_next = group_count_reg;
        gap_at_next      = gap_at_reg;
        gap_seen_next    = gap_seen_reg;
        group_value_next = group_value_reg;
        digit_count_next = digit_count_reg;
        failed_next      = failed_reg;
        do_close         = 1'b0;
        clear_gap        = 1'b0;
        gap_pos          = 4'd0;
        final_count      = group_count_reg;
        ok               = 1'b0;

        if (end_mark) begin
            if (!failed_reg) begin
                unique case (phase_reg)
                    PH_IN_GROUP: begin
                        do_close    = 1'b1;
                        final_count = group_count_reg + 4'd1;
                        if (!close_fail) begin
                            ok = gap_seen_reg ? (final_count < FULL_GROUPS)
                                              : (final_count == FULL_GROUPS);
                        end
                    end
                    PH_AFTER_GAP: begin
                        ok = gap_seen_reg ? (final_count < FULL_GROUPS)
                                          : (final_count == FULL_GROUPS);
                    end
                    default: ok = 1'b0;
                endcase
            end
            // start a fresh text
            phase_next       = PH_START;
            group_count_next = 4'd0;
            gap_at_next      = 4'd0;
            gap_seen_next    = 1'b0;
            group_value_next = '0;
            digit_count_next = 3'd0;
            failed_next      = 1'b0;
        end else if (!failed_reg) begin
            unique case (phase_reg)
                PH_START: begin
                    if (is_colon) begin
                        phase_next = PH_LEAD_COLON;
                    end else if (is_digit) begin
                        group_value_next = {12'd0, digit};
                        digit_count_next = 3'd1;
                        phase_next       = PH_IN_GROUP;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_LEAD_COLON: begin
                    if (is_colon) begin
                        gap_seen_next = 1'b1;
                        gap_at_next   = 4'd0;
                        gap_pos       = 4'd0;
                        clear_gap     = 1'b1;
                        phase_next    = PH_AFTER_GAP;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_IN_GROUP: begin
                    if (is_digit) begin
                        if (digit_count_reg >= MAX_DIGITS) begin
                            failed_next = 1'b1;
                        end else begin
                            group_value_next = {group_value_reg[11:0], digit};
                            digit_count_next = digit_count_reg + 3'd1;
                        end
                    end else begin
                        do_close = 1'b1;
                        if (close_fail || !is_colon) begin
                            failed_next = 1'b1;
                        end else begin
                            group_count_next = group_count_reg + 4'd1;
                            group_value_next = '0;
                            digit_count_next = 3'd0;
                            phase_next       = PH_AFTER_COLON;
                        end
                    end
                end
                PH_AFTER_COLON: begin
                    if (is_colon) begin
                        if (gap_seen_reg) begin
                            failed_next = 1'b1;
                        end else begin
                            gap_seen_next = 1'b1;
                            gap_at_next   = group_count_reg;
                            gap_pos       = group_count_reg;
                            clear_gap     = 1'b1;
                            phase_next    = PH_AFTER_GAP;
                        end
                    end else if (is_digit) begin
                        group_value_next = {12'd0, digit};
                        digit_count_next = 3'd1;
                        phase_next       = PH_IN_GROUP;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_AFTER_GAP: begin
                    if (is_digit) begin
                        group_value_next = {12'd0, digit};
                        digit_count_next = 3'd1;
                        phase_next       = PH_IN_GROUP;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                default: failed_next = 1'b1;
            endcase
        end
    end

    // Groups after the gap enter at the last slot and push earlier ones up,
    // so the zero run left by the gap shrinks from its top end.
    always_comb begin
        for (int i = 0; i < GROUPS - 1; i++) begin
            shift_src[i] = slot_reg[i + 1];
        end
        shift_src[GROUPS-1] = group_value_reg;
        for (int i = 0; i < GROUPS; i++) begin
            slot_next[i] = slot_reg[i];
            if (clear_gap && (4'(i) >= gap_pos)) begin
                slot_next[i] = '0;
            end else if (do_close && !close_fail) begin
                if (gap_seen_reg) begin
                    if (4'(i) >= gap_at_reg) slot_next[i] = shift_src[i];
                end else if (4'(i) == group_count_reg) begin
                    slot_next[i] = group_value_reg;
                end
            end
        end
    end

    always_comb begin
        result.ok        = ok;
        result.addr_high = '0;
        result.addr_low  = '0;
        if (ok) begin
            result.addr_high = {slot_next[0], slot_next[1], slot_next[2], slot_next[3]};
            result.addr_low  = {slot_next[4], slot_next[5], slot_next[6], slot_next[7]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_START;
            group_count_reg <= 4'd0;
            gap_at_reg      <= 4'd0;
            gap_seen_reg    <= 1'b0;
            group_value_reg <= '0;
            digit_count_reg <= 3'd0;
            failed_reg      <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            group_count_reg <= group_count_next;
            gap_at_reg      <= gap_at_next;
            gap_seen_reg    <= gap_seen_next;
            group_value_reg <= group_value_next;
            digit_count_reg <= digit_count_next;
            failed_reg      <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            for (int i = 0; i < GROUPS; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

[src/ipv6p_out_stage.sv]
// Result register of the IPv6 parser: holds one result until taken.
// Depends on ipv6p_pkg.
module ipv6p_out_stage
    import ipv6p_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  ipv6p_result_t result,
    input  logic          m_ready,
    output logic          m_valid,
    output ipv6p_result_t m_result
);

    logic          valid_reg, valid_next;
    ipv6p_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load)         valid_next = 1'b1;
        else if (m_ready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load) data_reg <= result;
    end

    assign m_valid  = valid_reg;
    assign m_result = data_reg;

endmodule

[src/ipv6_text_address_parser_top.sv]
// IPv6 text address parser, one character per request; one result per end mark.
// Timing: a character is registered, then parsed when it advances from the input register;
// m_tvalid is set from the result register once the end mark has been parsed.
// Throughput: one character per cycle while no end mark waits; an end mark waits while an untaken result is held.
// Reset: aresetn synchronous active low; clears parse state and both valid flags.
`include "ipv6_text_address_parser_top_defines.svh"

module ipv6_text_address_parser_top
    import ipv6p_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tlast,   // end_mark
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] addr_high, [127:64] addr_low
    output logic [0:0]   m_tuser    // [0] ok
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_ch_reg;
    logic          in_last_reg;
    logic          core_step;
    logic          out_load;
    ipv6p_result_t core_result;
    ipv6p_result_t out_result;

    // An end item may only advance when the result register can take it.
    assign core_step = in_valid_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign out_load  = core_step && in_last_reg;
    assign s_tready  = !in_valid_reg || core_step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) in_valid_next = 1'b1;
        else if (core_step)       in_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) in_valid_reg <= 1'b0;
        else          in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ipv6p_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (core_step),
        .ch       (in_ch_reg),
        .end_mark (in_last_reg),
        .result   (core_result)
    );

    ipv6p_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (core_result),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_result (out_result)
    );

    assign m_tdata = {out_result.addr_low, out_result.addr_high};
    assign m_tuser = out_result.ok;

    `IPV6P_ASSERT_IMPLIES(a_fail_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "failed with address")
    `IPV6P_ASSERT_IMPLIES(a_no_overrun, out_load && m_tvalid, m_tready, "result overwritten")
    `IPV6P_ASSERT_NEXT(a_result_follows, out_load, m_tvalid, "end item produced no result")
    `IPV6P_ASSERT_IMPLIES(a_empty_ready, !in_valid_reg, s_tready, "empty input refuses request")

endmodule
